@@ design/ezd_pkg.sv @@
// Shared types and constants for the EMA z-score anomaly detector.
package ezd_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALERT_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WARNING_THR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_THR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 3'd4;

	localparam logic [15:0] ALPHA_RST        = 16'd5243;
	localparam logic [15:0] ALERT_THR_RST    = 16'd640;
	localparam logic [15:0] WARNING_THR_RST  = 16'd768;
	localparam logic [15:0] CRITICAL_THR_RST = 16'd1024;
	localparam logic [7:0]  MIN_SAMPLES_RST  = 8'd5;

	// field widths
	localparam int CH_W   = 3;
	localparam int VAR_W  = 48;
	localparam int Z_W    = 16;
	localparam int SEV_W  = 2;
	localparam int CONF_W = 10;
	localparam int CNT_W  = 8;
	// result fields below the baseline: zscore, alert, severity, confidence
	localparam int RES_FIXED_W = Z_W + 1 + SEV_W + CONF_W;

	localparam logic [SEV_W-1:0] SEV_INFO     = 2'd0;
	localparam logic [SEV_W-1:0] SEV_WARNING  = 2'd1;
	localparam logic [SEV_W-1:0] SEV_CRITICAL = 2'd2;

	localparam logic [CONF_W-1:0] CONF_BASE = 10'd700;
	localparam logic [CONF_W-1:0] CONF_MAX  = 10'd999;

	// engine control from the top level
	typedef struct packed {
		logic start;
		logic seen;
	} eng_ctl_t;

	// engine results besides the mean
	typedef struct packed {
		logic [Z_W-1:0]   zscore;
		logic [VAR_W-1:0] variance;
	} eng_res_t;

endpackage

@@ design/ezd_engine.sv @@
// Sequenced arithmetic engine: mean/variance update, divide and square root for z.
module ezd_engine #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ezd_pkg::eng_ctl_t              ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] old_mean,
	input  logic [ezd_pkg::VAR_W-1:0]      old_var,
	input  logic [15:0]                    alpha,
	output logic                           done,
	output logic signed [SAMPLE_WIDTH-1:0] new_mean,
	output ezd_pkg::eng_res_t              res
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int D2_W   = 2 * SW;
	localparam int UW     = 65;
	localparam int ACC_W  = 64;
	localparam int MA_W   = 17;
	localparam int MB_W   = 32;
	localparam int PROD_W = MA_W + MB_W;
	localparam int T_W    = 50;
	localparam int STEP_W = 5;
	localparam int VW     = ezd_pkg::VAR_W;

	localparam logic [STEP_W-1:0] DIV_LAST  = 5'd31;
	localparam logic [STEP_W-1:0] SQRT_LAST = 5'd15;
	localparam logic [UW-1:0]     ROUND_HALF = 65'd32768;
	localparam logic [MA_W-1:0]   ONE_Q16    = 17'h10000;

	// sequencer states
	localparam logic [3:0] E_IDLE = 4'd0;
	localparam logic [3:0] E_DIFF = 4'd1;
	localparam logic [3:0] E_ABS  = 4'd2;
	localparam logic [3:0] E_SQ0  = 4'd3;
	localparam logic [3:0] E_SQ1  = 4'd4;
	localparam logic [3:0] E_SQ2  = 4'd5;
	localparam logic [3:0] E_M0   = 4'd6;
	localparam logic [3:0] E_M1   = 4'd7;
	localparam logic [3:0] E_M2   = 4'd8;
	localparam logic [3:0] E_M3   = 4'd9;
	localparam logic [3:0] E_M4   = 4'd10;
	localparam logic [3:0] E_M5   = 4'd11;
	localparam logic [3:0] E_ZCHK = 4'd12;
	localparam logic [3:0] E_DIV  = 4'd13;
	localparam logic [3:0] E_SQRT = 4'd14;

	logic [3:0]               state_q;
	logic [STEP_W-1:0]        step_q;
	logic                     done_q;

	logic signed [SW:0]       diff_q;
	logic                     neg_q;
	logic [SW-1:0]            ad_q;
	logic [MA_W-1:0]          beta_q;
	logic [PROD_W-1:0]        prod_q;
	logic [ACC_W-1:0]         acc_q;
	logic [D2_W-1:0]          d2full_q;
	logic signed [T_W-1:0]    t_q;
	logic [VW-1:0]            nv_q;
	logic [VW-1:0]            rem_q;
	logic [31:0]              fb_q;
	logic [31:0]              quo_q;
	logic [15:0]              root_q;
	logic [15:0]              z_q;
	logic signed [SW-1:0]     mean_q;

	logic [31:0]              ad32;
	logic [63:0]              d2_ext;
	logic [VW-1:0]            d2sat;
	logic [MA_W-1:0]          mul_a;
	logic [MB_W-1:0]          mul_b;
	logic [UW-1:0]            ua;
	logic [UW-1:0]            ub;
	logic                     usub;
	logic [UW-1:0]            ur;
	logic                     borrow;
	logic [15:0]              root_nx;

	assign ad32   = 32'(ad_q);
	assign d2_ext = 64'(d2full_q);
	// squared deviation clipped to the variance width
	assign d2sat  = (d2_ext[63:VW] != '0) ? '1 : d2_ext[VW-1:0];

	// shared adder/subtractor; top bit is the borrow for unsigned subtracts
	assign ur      = ua + (usub ? ~ub : ub) + UW'(usub);
	assign borrow  = ur[UW-1];
	assign root_nx = {root_q[14:0], ~borrow};

	// operand selection for the shared multiplier and adder
	always_comb begin
		ua    = '0;
		ub    = '0;
		usub  = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			E_DIFF: begin
				ua   = UW'(sample);
				ub   = UW'(old_mean);
				usub = 1'b1;
			end
			E_ABS: begin
				ub   = UW'(diff_q);
				usub = diff_q[SW];
			end
			E_SQ0: begin
				mul_a = MA_W'(ad32[15:0]);
				mul_b = ad32;
			end
			E_SQ1: begin
				mul_a = MA_W'(ad32[31:16]);
				mul_b = ad32;
			end
			E_SQ2: begin
				mul_a = {1'b0, alpha};
				mul_b = ad32;
				ua    = UW'(acc_q);
				ub    = UW'(prod_q) << 16;
			end
			E_M0: begin
				// rounded mean step: 32768 +/- alpha*|diff|
				mul_a = {1'b0, alpha};
				mul_b = MB_W'(d2sat[15:0]);
				ua    = ROUND_HALF;
				ub    = UW'(prod_q);
				usub  = neg_q;
			end
			E_M1: begin
				mul_a = beta_q;
				mul_b = MB_W'(old_var[15:0]);
				ua    = UW'(prod_q);
				ub    = ROUND_HALF;
			end
			E_M2: begin
				mul_a = {1'b0, alpha};
				mul_b = d2sat[VW-1:16];
				ua    = UW'(acc_q);
				ub    = UW'(prod_q);
			end
			E_M3: begin
				mul_a = beta_q;
				mul_b = old_var[VW-1:16];
				ua    = UW'(acc_q >> 16);
				ub    = UW'(prod_q);
			end
			E_M4: begin
				ua = UW'(acc_q);
				ub = UW'(prod_q);
			end
			E_M5: begin
				ua = UW'(old_mean);
				ub = UW'(t_q >>> 16);
			end
			E_ZCHK: begin
				// quotient overflow check: d2 / 2^16 >= variance
				ua   = UW'(d2_ext >> 16);
				ub   = UW'(nv_q);
				usub = 1'b1;
			end
			E_DIV: begin
				ua   = UW'({rem_q, fb_q[31]});
				ub   = UW'(nv_q);
				usub = 1'b1;
			end
			E_SQRT: begin
				ua   = UW'({rem_q[16:0], quo_q[31:30]});
				ub   = UW'({root_q, 2'b01});
				usub = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (ctl.start) begin
						if (ctl.seen) begin
							state_q <= E_DIFF;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				E_DIFF: state_q <= E_ABS;
				E_ABS:  state_q <= E_SQ0;
				E_SQ0:  state_q <= E_SQ1;
				E_SQ1:  state_q <= E_SQ2;
				E_SQ2:  state_q <= E_M0;
				E_M0:   state_q <= E_M1;
				E_M1:   state_q <= E_M2;
				E_M2:   state_q <= E_M3;
				E_M3:   state_q <= E_M4;
				E_M4:   state_q <= E_M5;
				E_M5:   state_q <= E_ZCHK;
				E_ZCHK: begin
					if (nv_q == '0 || !borrow) begin
						state_q <= E_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= E_DIV;
						step_q  <= DIV_LAST;
					end
				end
				E_DIV: begin
					if (step_q == '0) begin
						state_q <= E_SQRT;
						step_q  <= SQRT_LAST;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				E_SQRT: begin
					if (step_q == '0) begin
						state_q <= E_IDLE;
						done_q  <= 1'b1;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		unique case (state_q)
			E_IDLE: begin
				if (ctl.start) begin
					beta_q <= ONE_Q16 - {1'b0, alpha};
					if (!ctl.seen) begin
						// first sample of the channel loads the mean
						mean_q <= sample;
						nv_q   <= '0;
						z_q    <= '0;
					end
				end
			end
			E_DIFF: diff_q <= ur[SW:0];
			E_ABS: begin
				neg_q <= diff_q[SW];
				ad_q  <= ur[SW-1:0];
			end
			E_SQ1:  acc_q    <= ACC_W'(prod_q);
			E_SQ2:  d2full_q <= ur[D2_W-1:0];
			E_M0:   t_q      <= ur[T_W-1:0];
			E_M1:   acc_q    <= ur[ACC_W-1:0];
			E_M2:   acc_q    <= ur[ACC_W-1:0];
			E_M3:   acc_q    <= ur[ACC_W-1:0];
			E_M4:   nv_q     <= ur[VW-1:0];
			E_M5:   mean_q   <= ur[SW-1:0];
			E_ZCHK: begin
				if (nv_q == '0) begin
					z_q <= '0;
				end else if (!borrow) begin
					z_q <= '1;
				end else begin
					rem_q <= d2_ext[63:16];
					fb_q  <= {d2_ext[15:0], 16'h0000};
				end
			end
			E_DIV: begin
				// restoring divide, one quotient bit per cycle
				if (!borrow) begin
					rem_q <= ur[VW-1:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[VW-2:0], fb_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
				fb_q <= {fb_q[30:0], 1'b0};
				if (step_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			E_SQRT: begin
				// digit-by-digit square root, two radicand bits per cycle
				if (!borrow) begin
					rem_q <= VW'(ur[16:0]);
				end else begin
					rem_q <= VW'({rem_q[14:0], quo_q[31:30]});
				end
				root_q <= root_nx;
				quo_q  <= {quo_q[29:0], 2'b00};
				if (step_q == '0) begin
					z_q <= root_nx;
				end
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign new_mean     = mean_q;
	assign res.zscore   = z_q;
	assign res.variance = nv_q;

endmodule

@@ design/ema_zscore_anomaly_detector_top.sv @@
// Top level of the EMA z-score anomaly detector: handshakes, config, channel store, results.
//
// Samples arrive on the s_ stream: s_tdata carries the signed Q16.8 sample and
// s_tuser the channel number. Each transfer to a channel below CHANNELS updates
// that channel's moving mean and variance; every transfer yields one result on
// the m_ stream: z-score (Q8.8), alert, severity, confidence and the updated mean.
// One sample is in work at a time; s_tready is low from acceptance until the
// result is loaded into the output register. A channel's first sample only
// loads its mean, a sample with zero variance or saturated z skips the divide,
// and any other runs through the 32-step restoring divider and the 16-step
// square root that share one adder in the engine.
// The output register holds a result until m_tready takes it; a new sample may
// be accepted meanwhile, and the engine then waits to load its result.
// Reset clears the per-channel seen flags (so every channel starts empty),
// drops any pending result and restores the register defaults. Config writes
// belong to idle periods.
module ema_zscore_anomaly_detector_top #(
	parameter int CHANNELS     = 8,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
	// channel
	input  logic [ezd_pkg::CH_W-1:0]             s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// zscore, alert, severity, confidence, baseline
	output logic [((ezd_pkg::RES_FIXED_W+SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
	input  logic                                 cfg_we,
	input  logic [ezd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ezd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int OUT_TW = ((ezd_pkg::RES_FIXED_W + SW + 7) / 8) * 8;
	localparam int Z_W    = ezd_pkg::Z_W;
	localparam int CNT_W  = ezd_pkg::CNT_W;
	localparam int Z50_W  = Z_W + 6;
	localparam int CR_W   = 15;

	// sequencer states
	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_START = 2'd1;
	localparam logic [1:0] T_WAIT  = 2'd2;
	localparam logic [1:0] T_FIN   = 2'd3;

	logic [1:0]                  tstate_q;
	logic [15:0]                 alpha_q;
	logic [15:0]                 alert_thr_q;
	logic [15:0]                 warn_thr_q;
	logic [15:0]                 crit_thr_q;
	logic [7:0]                  min_q;
	logic [CHANNELS-1:0]         seen_q;
	logic                        m_tvalid_q;
	logic [OUT_TW-1:0]           out_data_q;

	logic [IDX_W-1:0]            idx_q;
	logic                        in_range_q;
	logic signed [SW-1:0]        sample_q;
	logic signed [SW-1:0]        rd_mean_q;
	logic [ezd_pkg::VAR_W-1:0]   rd_var_q;
	logic [CNT_W-1:0]            rd_cnt_q;
	logic [CNT_W-1:0]            cnt_q;

	// per-channel store
	logic signed [SW-1:0]        mean_mem [CHANNELS];
	logic [ezd_pkg::VAR_W-1:0]   var_mem  [CHANNELS];
	logic [CNT_W-1:0]            cnt_mem  [CHANNELS];

	logic                        in_xfer;
	logic [IDX_W-1:0]            idx_in;
	logic                        in_range_in;
	logic                        mem_we;
	logic                        out_load;
	logic [CNT_W-1:0]            cnt_old;
	logic [CNT_W-1:0]            cnt_new;

	ezd_pkg::eng_ctl_t           eng_ctl;
	ezd_pkg::eng_res_t           eng_res;
	logic                        eng_done;
	logic signed [SW-1:0]        eng_mean;

	logic [Z_W-1:0]              z_o;
	logic                        alert_o;
	logic [ezd_pkg::SEV_W-1:0]   sev_o;
	logic [ezd_pkg::CONF_W-1:0]  conf_o;
	logic signed [SW-1:0]        base_o;
	logic [Z50_W-1:0]            z50;
	logic [CR_W-1:0]             conf_raw;

	assign in_xfer     = s_tvalid && s_tready;
	assign s_tready    = (tstate_q == T_IDLE);
	assign idx_in      = IDX_W'(s_tuser);
	assign in_range_in = 32'(s_tuser) < 32'(CHANNELS);
	assign mem_we      = (tstate_q == T_WAIT) && eng_done;
	assign out_load    = (tstate_q == T_FIN) && (!m_tvalid_q || m_tready);

	// saturating sample count; an unseen channel counts from zero
	assign cnt_old = seen_q[idx_q] ? rd_cnt_q : '0;
	assign cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;

	assign eng_ctl.start = (tstate_q == T_START) && in_range_q;
	assign eng_ctl.seen  = seen_q[idx_q];

	ezd_engine #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (eng_ctl),
		.sample   (sample_q),
		.old_mean (rd_mean_q),
		.old_var  (rd_var_q),
		.alpha    (alpha_q),
		.done     (eng_done),
		.new_mean (eng_mean),
		.res      (eng_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ezd_pkg::ALPHA_RST;
			alert_thr_q <= ezd_pkg::ALERT_THR_RST;
			warn_thr_q  <= ezd_pkg::WARNING_THR_RST;
			crit_thr_q  <= ezd_pkg::CRITICAL_THR_RST;
			min_q       <= ezd_pkg::MIN_SAMPLES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ezd_pkg::REG_ALPHA:        alpha_q     <= cfg_data;
				ezd_pkg::REG_ALERT_THR:    alert_thr_q <= cfg_data;
				ezd_pkg::REG_WARNING_THR:  warn_thr_q  <= cfg_data;
				ezd_pkg::REG_CRITICAL_THR: crit_thr_q  <= cfg_data;
				ezd_pkg::REG_MIN_SAMPLES:  min_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// control: sequencer, seen flags, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q   <= T_IDLE;
			seen_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (tstate_q)
				T_IDLE:  if (s_tvalid) tstate_q <= T_START;
				T_START: tstate_q <= in_range_q ? T_WAIT : T_FIN;
				T_WAIT:  if (eng_done) tstate_q <= T_FIN;
				T_FIN:   if (out_load) tstate_q <= T_IDLE;
				default: tstate_q <= T_IDLE;
			endcase
			if (mem_we) begin
				seen_q[idx_q] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// input capture and channel store access
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			idx_q      <= idx_in;
			in_range_q <= in_range_in;
			sample_q   <= s_tdata[SW-1:0];
			rd_mean_q  <= mean_mem[idx_in];
			rd_var_q   <= var_mem[idx_in];
			rd_cnt_q   <= cnt_mem[idx_in];
		end
		if (mem_we) begin
			mean_mem[idx_q] <= eng_mean;
			var_mem[idx_q]  <= eng_res.variance;
			cnt_mem[idx_q]  <= cnt_new;
			cnt_q           <= cnt_new;
		end
		if (out_load) begin
			out_data_q <= OUT_TW'({base_o, conf_o, sev_o, alert_o, z_o});
		end
	end

	// alert, severity and confidence from z
	always_comb begin
		z_o      = in_range_q ? eng_res.zscore : '0;
		base_o   = in_range_q ? eng_mean : '0;
		alert_o  = in_range_q && (z_o > alert_thr_q) && (cnt_q > min_q);
		// 50*z as shifts and adds, then /256
		z50      = Z50_W'({z_o, 5'b0}) + Z50_W'({z_o, 4'b0}) + Z50_W'({z_o, 1'b0});
		conf_raw = CR_W'(ezd_pkg::CONF_BASE) + CR_W'(z50[Z50_W-1:8]);
		sev_o    = ezd_pkg::SEV_INFO;
		conf_o   = '0;
		if (alert_o) begin
			if (z_o > crit_thr_q) begin
				sev_o = ezd_pkg::SEV_CRITICAL;
			end else if (z_o > warn_thr_q) begin
				sev_o = ezd_pkg::SEV_WARNING;
			end
			conf_o = (conf_raw > CR_W'(ezd_pkg::CONF_MAX)) ? ezd_pkg::CONF_MAX
				: conf_raw[ezd_pkg::CONF_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

endmodule
